// File: rtl/dpcm_enc_pkg.sv
// ----------------------------------------------------------------------------
// dpcm_enc_pkg
// Shared constants, widths and result types for the DPCM unary pixel encoder.
// ----------------------------------------------------------------------------
package dpcm_enc_pkg;

    localparam int PIXEL_W     = 8;
    localparam int CODE_W      = 33;
    localparam int LEN_W       = 6;

    // Quantiser step and the largest quotient magnitude that is still coded.
    localparam int QSTEP       = 15;
    localparam int QMAX        = 16;
    localparam int QMAG_W      = 5;

    // Division by the step: floor(m / 15) == (m * 137) >> 11 for 0 <= m <= 255.
    localparam int RECIP       = 137;
    localparam int RECIP_SHIFT = 11;
    localparam int PROD_W      = 16;

    // Length of the raw code that opens a row.
    localparam logic [LEN_W-1:0] RAW_LEN = LEN_W'(PIXEL_W);

    typedef struct packed {
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
        logic              overflow;
    } code_res_t;

    typedef struct packed {
        code_res_t          res;
        logic [PIXEL_W-1:0] recon;
    } quant_out_t;

endpackage

// File: rtl/dpcm_pixel_if.sv
// ----------------------------------------------------------------------------
// dpcm_pixel_if
// Valid/ready channel that carries one pixel item and its row start mark.
// ----------------------------------------------------------------------------
interface dpcm_pixel_if;

    logic       valid;
    logic       ready;
    logic [7:0] pixel;
    logic       row_start;

    modport source (output valid, output pixel, output row_start, input ready);
    modport sink   (input valid, input pixel, input row_start, output ready);

endinterface

// File: rtl/dpcm_code_if.sv
// ----------------------------------------------------------------------------
// dpcm_code_if
// Valid/ready channel that carries one code word item.
// ----------------------------------------------------------------------------
interface dpcm_code_if;

    logic        valid;
    logic        ready;
    logic [32:0] code_bits;
    logic [5:0]  code_length;
    logic        overflow;

    modport source (output valid, output code_bits, output code_length,
                    output overflow, input ready);
    modport sink   (input valid, input code_bits, input code_length,
                    input overflow, output ready);

endinterface

// File: rtl/dpcm_enc_quant.sv
// ----------------------------------------------------------------------------
// dpcm_enc_quant
// Prediction, step-15 quantiser, reconstruction update and unary coder, with a raw code at row start.
// ----------------------------------------------------------------------------
module dpcm_enc_quant (
    input  logic [dpcm_enc_pkg::PIXEL_W-1:0] pixel,
    input  logic                             row_start,
    input  logic [dpcm_enc_pkg::PIXEL_W-1:0] recon,
    output dpcm_enc_pkg::quant_out_t         result
);
    import dpcm_enc_pkg::*;

    logic signed [PIXEL_W:0] diff;
    logic                    neg;
    logic [PIXEL_W-1:0]      mag;
    logic [PROD_W-1:0]       prod;
    logic [QMAG_W-1:0]       qmag;
    logic [PIXEL_W:0]        step;
    logic [PIXEL_W-1:0]      recon_adv;
    logic [LEN_W-1:0]        n;
    logic                    ovf;
    logic [CODE_W-2:0]       ones;

    always_comb
    begin
        diff = $signed({1'b0, pixel}) - $signed({1'b0, recon});
        neg  = diff[PIXEL_W];
        mag  = neg ? PIXEL_W'(-diff) : diff[PIXEL_W-1:0];

        // Magnitude of the quotient, truncated toward zero.
        prod = PROD_W'(mag) * PROD_W'(RECIP);
        qmag = prod[PROD_W-1:RECIP_SHIFT];
        step = (PIXEL_W+1)'({qmag, 4'b0000}) - (PIXEL_W+1)'(qmag);

        // The new value lies between the old one and the pixel.
        recon_adv = neg ? recon - step[PIXEL_W-1:0] : recon + step[PIXEL_W-1:0];

        ovf = (qmag > QMAG_W'(QMAX));
        if (qmag == '0)
        begin
            n = '0;
        end
        else if (neg)
        begin
            n = {qmag, 1'b0};
        end
        else
        begin
            n = {qmag, 1'b0} - LEN_W'(1);
        end

        ones = {(CODE_W-1){1'b1}} >> (LEN_W'(CODE_W - 1) - n);

        if (row_start)
        begin
            result.res.code_bits   = CODE_W'(pixel);
            result.res.code_length = RAW_LEN;
            result.res.overflow    = 1'b0;
            result.recon           = pixel;
        end
        else if (ovf)
        begin
            result.res.code_bits   = '0;
            result.res.code_length = '0;
            result.res.overflow    = 1'b1;
            result.recon           = recon_adv;
        end
        else
        begin
            result.res.code_bits   = {ones, 1'b0};
            result.res.code_length = n + LEN_W'(1);
            result.res.overflow    = 1'b0;
            result.recon           = recon_adv;
        end
    end

endmodule

// File: rtl/dpcm_unary_pixel_encoder.sv
// ----------------------------------------------------------------------------
// dpcm_unary_pixel_encoder
// Row-wise DPCM encoder: raw pixel at row start, then unary-coded step-15
// quantiser indices against a running reconstruction.
// ----------------------------------------------------------------------------
// Path: an accepted input item is held in the input register, and its result
// is then registered in the result register, from which it is offered.
// Throughput: one item per cycle while the output is not stalled; the
// reconstruction loop (subtract, constant divide by 15, multiply-add) closes through one register.
// Reset: asynchronous, active low; clears valid flags and the reconstruction
// to zero. Payload registers are not reset.
module dpcm_unary_pixel_encoder (
    input  logic         clk,
    input  logic         rst_n,
    dpcm_pixel_if.sink   samples,
    dpcm_code_if.source  codes
);
    import dpcm_enc_pkg::*;

    // Input register stage.
    logic                 in_valid_reg;
    logic [PIXEL_W-1:0]   pixel_reg;
    logic                 row_start_reg;

    // Reconstruction held on the decoder side of the loop.
    logic [PIXEL_W-1:0]   recon_reg;

    // Result register stage.
    logic                 out_valid_reg;
    code_res_t            res_reg;

    quant_out_t           quant;
    logic                 out_free;
    logic                 advance;

    // The result register can take a new item when it is empty or being drained.
    // The input stage moves forward whenever it holds an item and there is room.
    assign out_free      = !out_valid_reg || codes.ready;
    assign advance       = in_valid_reg && out_free;
    assign samples.ready = !in_valid_reg || out_free;

    dpcm_enc_quant u_quant (
        .pixel     (pixel_reg),
        .row_start (row_start_reg),
        .recon     (recon_reg),
        .result    (quant)
    );

    // Control registers, including the reconstruction, are reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            recon_reg     <= '0;
        end
        else
        begin
            if (samples.ready)
            begin
                in_valid_reg <= samples.valid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance)
            begin
                recon_reg <= quant.recon;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (samples.ready && samples.valid)
        begin
            pixel_reg     <= samples.pixel;
            row_start_reg <= samples.row_start;
        end
        if (advance)
        begin
            res_reg <= quant.res;
        end
    end

    assign codes.valid       = out_valid_reg;
    assign codes.code_bits   = res_reg.code_bits;
    assign codes.code_length = res_reg.code_length;
    assign codes.overflow    = res_reg.overflow;

    // The reconstruction only moves when an item passes into the result stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(recon_reg))
        else $error("reconstruction changed without an item advancing");

    // An item that advances is always offered on the output in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced item was lost before the result register");

    // An overflowed item never carries a code.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.overflow) |-> (res_reg.code_length == '0))
        else $error("overflow item carries a non-empty code");

    // Code lengths never exceed the code word width.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (res_reg.code_length <= LEN_W'(CODE_W)))
        else $error("code length beyond the code word width");

endmodule
